// ----- sv/acfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Addressed command frame receiver package
// Shared types, register indexes and constants of the frame receiver.
// ----------------------------------------------------------------------------
package acfr_pkg;

   localparam int MAX_ARGS_DEFAULT = 5;
   localparam int OUT_ARGS         = 5;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 8;

   localparam logic [7:0] ADDR_LOW_MASK         = 8'h7F;
   localparam logic [7:0] START_MARKER_RESET    = 8'h00;
   localparam logic [7:0] REQUEST_MASK_RESET    = 8'h80;
   localparam logic [6:0] OWN_ADDRESS_RESET     = 7'h00;
   localparam logic [7:0] BROADCAST_RESET       = 8'hFF;
   localparam logic       CHECK_ENABLE_RESET    = 1'b0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_MARKER      = 3'd0,
      CSR_REQUEST_MASK      = 3'd1,
      CSR_OWN_ADDRESS       = 3'd2,
      CSR_BROADCAST_ADDRESS = 3'd3,
      CSR_CHECK_ENABLE      = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_ADDR    = 3'd1,
      PH_LEN     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CHECK   = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_reset;
   } acfr_req_type;

   typedef struct packed {
      logic [7:0] command_code;
      logic [7:0] arg0;
      logic [7:0] arg1;
      logic [7:0] arg2;
      logic [7:0] arg3;
      logic [7:0] arg4;
      logic [2:0] arg_count;
      logic       was_broadcast;
      logic       checksum_ok;
   } acfr_rsp_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] request_mask;
      logic [6:0] own_address;
      logic [7:0] broadcast_address;
      logic       check_enable;
   } acfr_cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } acfr_queue_status_type;

endpackage

// ----- sv/acfr_parser.sv -----
// ----------------------------------------------------------------------------
// Frame parser
// Walks the received bytes through the frame, keeps the running checksum and
// the leading payload bytes, and pushes a result record at the checksum byte.
// ----------------------------------------------------------------------------
module acfr_parser
   import acfr_pkg::*;
#(
   parameter int MAX_ARGS = MAX_ARGS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  acfr_cfg_type cfg,
   input  logic         accept,
   input  acfr_req_type item,
   output logic         push_valid,
   output acfr_rsp_type push_item
);

   localparam int LIMIT = (MAX_ARGS < OUT_ARGS) ? MAX_ARGS : OUT_ARGS;
   localparam int KEEP  = LIMIT + 1;

   phase_type  phase_ff, phase_in, phase_eff;
   logic [7:0] addr_byte_ff, addr_byte_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] payload_index_ff, payload_index_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic       to_us_ff, to_us_in;
   logic [7:0] captured_ff [KEEP];
   logic [7:0] captured_in [KEEP];
   logic [7:0] index_next;
   logic [7:0] length_less_one;
   logic [7:0] raw_args [OUT_ARGS];
   logic       sum_ok;
   logic       addr_match;

   assign phase_eff  = item.frame_reset ? PH_HUNT : phase_ff;
   assign index_next = payload_index_ff + 8'd1;
   assign sum_ok     = (item.data_byte == (running_sum_ff + 8'd1));
   assign addr_match = ((item.data_byte & cfg.request_mask) != 8'd0) &&
                       (((item.data_byte & ADDR_LOW_MASK) == {1'b0, cfg.own_address}) ||
                        (item.data_byte == cfg.broadcast_address));
   assign length_less_one = frame_length_ff - 8'd1;

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_eff)
            PH_ADDR:    phase_in = PH_LEN;
            PH_LEN:     phase_in = (item.data_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            PH_PAYLOAD: phase_in = (index_next >= frame_length_ff) ? PH_CHECK : PH_PAYLOAD;
            PH_HUNT, PH_CHECK:
               phase_in = (item.data_byte == cfg.start_marker) ? PH_ADDR : PH_HUNT;
            default:    phase_in = PH_HUNT;
         endcase
      end
   end

   always_comb begin
      addr_byte_in     = addr_byte_ff;
      frame_length_in  = frame_length_ff;
      payload_index_in = payload_index_ff;
      running_sum_in   = running_sum_ff;
      to_us_in         = to_us_ff;
      captured_in      = captured_ff;
      push_valid       = 1'b0;
      if (accept) begin
         unique case (phase_eff)
            PH_ADDR: begin
               addr_byte_in   = item.data_byte;
               running_sum_in = item.data_byte;
               to_us_in       = addr_match;
            end
            PH_LEN: begin
               frame_length_in  = item.data_byte;
               running_sum_in   = running_sum_ff + item.data_byte;
               payload_index_in = 8'd0;
            end
            PH_PAYLOAD: begin
               for (int i = 0; i < KEEP; i++) begin
                  if (payload_index_ff == 8'(i)) begin
                     captured_in[i] = item.data_byte;
                  end
               end
               running_sum_in   = running_sum_ff + item.data_byte;
               payload_index_in = index_next;
            end
            PH_CHECK: begin
               push_valid = to_us_ff && (frame_length_ff != 8'd0) &&
                            (sum_ok || !cfg.check_enable);
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar g = 0; g < OUT_ARGS; g++) begin : g_args
      if (g + 1 < KEEP) begin : g_kept
         assign raw_args[g] = captured_ff[g+1];
      end else begin : g_absent
         assign raw_args[g] = 8'd0;
      end
   end

   always_comb begin
      push_item.command_code  = captured_ff[0];
      push_item.arg0          = raw_args[0];
      push_item.arg1          = raw_args[1];
      push_item.arg2          = raw_args[2];
      push_item.arg3          = raw_args[3];
      push_item.arg4          = raw_args[4];
      push_item.arg_count     = (length_less_one > 8'(LIMIT)) ? 3'(LIMIT)
                                                              : length_less_one[2:0];
      push_item.was_broadcast = (addr_byte_ff == cfg.broadcast_address);
      push_item.checksum_ok   = sum_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         addr_byte_ff     <= 8'd0;
         frame_length_ff  <= 8'd0;
         payload_index_ff <= 8'd0;
         running_sum_ff   <= 8'd0;
         to_us_ff         <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         addr_byte_ff     <= addr_byte_in;
         frame_length_ff  <= frame_length_in;
         payload_index_ff <= payload_index_in;
         running_sum_ff   <= running_sum_in;
         to_us_ff         <= to_us_in;
      end
   end

   always_ff @(posedge clock) begin
      captured_ff <= captured_in;
   end

endmodule

// ----- sv/acfr_queue.sv -----
// ----------------------------------------------------------------------------
// Result queue
// Short first-in first-out queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module acfr_queue
   import acfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  acfr_rsp_type          push_item,
   input  logic                  pop,
   output acfr_rsp_type          pop_item,
   output acfr_queue_status_type status
);

   acfr_rsp_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/acfr_emitter.sv -----
// ----------------------------------------------------------------------------
// Result output stage
// Takes records from the queue, clears the argument bytes beyond the count
// and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module acfr_emitter
   import acfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  acfr_queue_status_type status,
   input  acfr_rsp_type          pop_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output acfr_rsp_type          rsp_item
);

   logic         valid_ff, valid_in;
   acfr_rsp_type item_ff, item_in;

   assign pop       = !status.empty && (!valid_ff || rsp_ready);
   assign valid_in  = pop || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_comb begin
      item_in      = pop_item;
      item_in.arg0 = (pop_item.arg_count > 3'd0) ? pop_item.arg0 : 8'd0;
      item_in.arg1 = (pop_item.arg_count > 3'd1) ? pop_item.arg1 : 8'd0;
      item_in.arg2 = (pop_item.arg_count > 3'd2) ? pop_item.arg2 : 8'd0;
      item_in.arg3 = (pop_item.arg_count > 3'd3) ? pop_item.arg3 : 8'd0;
      item_in.arg4 = (pop_item.arg_count > 3'd4) ? pop_item.arg4 : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- sv/addressed_command_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// Addressed command frame receiver
// Finds addressed command frames in a byte stream and delivers the command
// byte and its argument bytes of each frame meant for this station.
// ----------------------------------------------------------------------------
//  Channel  Ports                             Carries
//  req      req_valid, req_ready, req_item    one received byte, frame reset
//  rsp      rsp_valid, rsp_ready, rsp_item    command, arguments, flags
//  csr      csr_write, csr_index, csr_data    register write, no wait
//
//  One byte is taken in every cycle while req_ready is high; the parser state
//  advances once per byte.
//  A result is written into the result queue when its checksum byte is
//  accepted, then into the output register when it is free or being emptied.
//  Reset is synchronous and returns the state and configuration registers to their default values.
//  req_ready falls while the result queue holds two records; the output
//  register then holds a third result that has not yet been taken.
// ----------------------------------------------------------------------------
module addressed_command_frame_receiver_core
   import acfr_pkg::*;
#(
   parameter int MAX_ARGS = MAX_ARGS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  acfr_req_type           req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output acfr_rsp_type           rsp_item,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   acfr_cfg_type          cfg_ff, cfg_in;
   acfr_queue_status_type status;
   acfr_rsp_type          push_item;
   acfr_rsp_type          pop_item;
   logic                  accept;
   logic                  push_valid;
   logic                  pop;

   assign req_ready = !status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_MARKER:      cfg_in.start_marker      = csr_data;
            CSR_REQUEST_MASK:      cfg_in.request_mask      = csr_data;
            CSR_OWN_ADDRESS:       cfg_in.own_address       = csr_data[6:0];
            CSR_BROADCAST_ADDRESS: cfg_in.broadcast_address = csr_data;
            CSR_CHECK_ENABLE:      cfg_in.check_enable      = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker      <= START_MARKER_RESET;
         cfg_ff.request_mask      <= REQUEST_MASK_RESET;
         cfg_ff.own_address       <= OWN_ADDRESS_RESET;
         cfg_ff.broadcast_address <= BROADCAST_RESET;
         cfg_ff.check_enable      <= CHECK_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   acfr_parser #(
      .MAX_ARGS (MAX_ARGS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .item       (req_item),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   acfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (status)
   );

   acfr_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .pop_item  (pop_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- sv/acfr_checker.sv -----
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Watches the result port of the frame receiver for consistent results.
// ----------------------------------------------------------------------------
module acfr_checker
   import acfr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input acfr_rsp_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("A result transfer was dropped or changed while stalled.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.arg_count <= 3'd5)
      else $error("The argument count exceeds five.");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.arg_count < 3'd5 |-> rsp_item.arg4 == 8'd0)
      else $error("An absent argument byte is not zero.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A result is offered straight after reset.");

endmodule

bind addressed_command_frame_receiver_core acfr_checker u_acfr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

// ----- sim/addressed_command_frame_receiver_core_tb.sv -----
// ----------------------------------------------------------------------------
// Addressed command frame receiver testbench
// Streams framed and stray bytes into the receiver under several register
// settings, predicts every command record in a scoreboard and checks each
// record that leaves the result channel, with random idling on both sides.
// ----------------------------------------------------------------------------
class frame_scoreboard;

   localparam int KEEP      = acfr_pkg::MAX_ARGS_DEFAULT + 1;
   localparam int ARG_LIMIT = (acfr_pkg::MAX_ARGS_DEFAULT < acfr_pkg::OUT_ARGS) ?
                              acfr_pkg::MAX_ARGS_DEFAULT : acfr_pkg::OUT_ARGS;

   acfr_pkg::acfr_cfg_type  regs;
   acfr_pkg::phase_type     parse_phase;
   logic [7:0]              addr_seen;
   logic [7:0]              length_seen;
   logic [7:0]              payload_pos;
   logic [7:0]              byte_sum;
   logic [7:0]              kept [KEEP];
   bit                      for_us;
   acfr_pkg::acfr_rsp_type  due_records [$];
   int                      fault_count;

   function new();
      regs.start_marker      = acfr_pkg::START_MARKER_RESET;
      regs.request_mask      = acfr_pkg::REQUEST_MASK_RESET;
      regs.own_address       = acfr_pkg::OWN_ADDRESS_RESET;
      regs.broadcast_address = acfr_pkg::BROADCAST_RESET;
      regs.check_enable      = acfr_pkg::CHECK_ENABLE_RESET;
      parse_phase = acfr_pkg::PH_HUNT;
      addr_seen   = 8'h00;
      length_seen = 8'h00;
      payload_pos = 8'h00;
      byte_sum    = 8'h00;
      for (int i = 0; i < KEEP; i++) kept[i] = 8'h00;
      for_us      = 1'b0;
      fault_count = 0;
   endfunction

   function void set_reg(acfr_pkg::csr_index_type idx, logic [7:0] value);
      case (idx)
         acfr_pkg::CSR_START_MARKER:      regs.start_marker      = value;
         acfr_pkg::CSR_REQUEST_MASK:      regs.request_mask      = value;
         acfr_pkg::CSR_OWN_ADDRESS:       regs.own_address       = value[6:0];
         acfr_pkg::CSR_BROADCAST_ADDRESS: regs.broadcast_address = value;
         acfr_pkg::CSR_CHECK_ENABLE:      regs.check_enable      = value[0];
         default: ;
      endcase
   endfunction

   function void note_byte(acfr_pkg::acfr_req_type item);
      logic [7:0]             b;
      logic                   sum_ok;
      acfr_pkg::acfr_rsp_type rec;
      logic [7:0]             args [acfr_pkg::OUT_ARGS];
      int                     cnt;
      b = item.data_byte;
      if (item.frame_reset) parse_phase = acfr_pkg::PH_HUNT;
      case (parse_phase)
         acfr_pkg::PH_ADDR: begin
            addr_seen = b;
            byte_sum  = b;
            for_us = ((b & regs.request_mask) != 8'h00) &&
                     (((b & acfr_pkg::ADDR_LOW_MASK) == {1'b0, regs.own_address}) ||
                      (b == regs.broadcast_address));
            parse_phase = acfr_pkg::PH_LEN;
         end
         acfr_pkg::PH_LEN: begin
            length_seen = b;
            byte_sum    = byte_sum + b;
            payload_pos = 8'h00;
            for (int i = 0; i < KEEP; i++) kept[i] = 8'h00;
            parse_phase = (b == 8'h00) ? acfr_pkg::PH_CHECK : acfr_pkg::PH_PAYLOAD;
         end
         acfr_pkg::PH_PAYLOAD: begin
            if (payload_pos < KEEP) kept[payload_pos] = b;
            byte_sum    = byte_sum + b;
            payload_pos = payload_pos + 8'd1;
            if (payload_pos >= length_seen) parse_phase = acfr_pkg::PH_CHECK;
         end
         acfr_pkg::PH_CHECK: begin
            sum_ok = (b == 8'(byte_sum + 8'd1));
            if (for_us && length_seen != 8'h00 && (sum_ok || !regs.check_enable)) begin
               cnt = int'(length_seen) - 1;
               if (cnt > ARG_LIMIT) cnt = ARG_LIMIT;
               for (int i = 0; i < acfr_pkg::OUT_ARGS; i++)
                  args[i] = (i < cnt) ? kept[i + 1] : 8'h00;
               rec.command_code  = kept[0];
               rec.arg0          = args[0];
               rec.arg1          = args[1];
               rec.arg2          = args[2];
               rec.arg3          = args[3];
               rec.arg4          = args[4];
               rec.arg_count     = 3'(cnt);
               rec.was_broadcast = (addr_seen == regs.broadcast_address);
               rec.checksum_ok   = sum_ok;
               due_records.push_back(rec);
            end
            parse_phase = (b == regs.start_marker) ? acfr_pkg::PH_ADDR : acfr_pkg::PH_HUNT;
         end
         default: begin
            parse_phase = (b == regs.start_marker) ? acfr_pkg::PH_ADDR : acfr_pkg::PH_HUNT;
         end
      endcase
   endfunction

   function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= 10)
            $display("command record mismatch on %s: expected %02h, got %02h",
                     name, want, got);
      end
   endfunction

   function void check_result(acfr_pkg::acfr_rsp_type got);
      acfr_pkg::acfr_rsp_type want;
      if (due_records.size() == 0) begin
         fault_count++;
         if (fault_count <= 10)
            $display("command record %h arrived with none outstanding", got);
         return;
      end
      want = due_records.pop_front();
      compare_field("command_code",  want.command_code,  got.command_code);
      compare_field("arg0",          want.arg0,          got.arg0);
      compare_field("arg1",          want.arg1,          got.arg1);
      compare_field("arg2",          want.arg2,          got.arg2);
      compare_field("arg3",          want.arg3,          got.arg3);
      compare_field("arg4",          want.arg4,          got.arg4);
      compare_field("arg_count",     want.arg_count,     got.arg_count);
      compare_field("was_broadcast", want.was_broadcast, got.was_broadcast);
      compare_field("checksum_ok",   want.checksum_ok,   got.checksum_ok);
   endfunction

   function int outstanding();
      return due_records.size();
   endfunction

endclass

module addressed_command_frame_receiver_core_tb;
   import acfr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 4000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   acfr_req_type           req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   acfr_rsp_type           rsp_item;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   frame_scoreboard sb = new();
   acfr_cfg_type    cur_cfg;
   acfr_cfg_type    plans [5];
   bit              calm        = 1'b0;
   bit              chained     = 1'b0;
   bit              force_reset = 1'b0;
   int              bytes_sent  = 0;
   int              stall_cycles = 0;

   addressed_command_frame_receiver_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 7);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) sb.set_reg(csr_index_type'(csr_index), csr_data);
         if (req_valid && req_ready) sb.note_byte(req_item);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("addressed_command_frame_receiver_core verification failed");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic abandon);
      int gap;
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= acfr_req_type'{data_byte: value, frame_reset: abandon};
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(input acfr_cfg_type s);
      write_reg(CSR_START_MARKER,      s.start_marker);
      write_reg(CSR_REQUEST_MASK,      s.request_mask);
      write_reg(CSR_OWN_ADDRESS,       {1'b0, s.own_address});
      write_reg(CSR_BROADCAST_ADDRESS, s.broadcast_address);
      write_reg(CSR_CHECK_ENABLE,      {7'b0, s.check_enable});
      csr_write <= 1'b0;
      cur_cfg = s;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_frame(input logic [7:0] addr, input int len,
                             input bit bad_sum, input bit aim);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] chk;
      bit         lead;
      lead = force_reset || ($urandom_range(0, 99) < 5);
      force_reset = 1'b0;
      if (lead) chained = 1'b0;
      if (!chained) send_byte(cur_cfg.start_marker, lead);
      send_byte(addr, 1'b0);
      sum = addr + len[7:0];
      send_byte(len[7:0], 1'b0);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         if (aim && i == len - 1) b = cur_cfg.start_marker - 8'd1 - sum;
         sum = sum + b;
         send_byte(b, 1'b0);
      end
      chk = sum + 8'd1;
      if (bad_sum) chk = chk ^ 8'($urandom_range(1, 255));
      chained = (chk == cur_cfg.start_marker);
      send_byte(chk, 1'b0);
   endtask

   task automatic random_frame();
      logic [7:0] addr;
      int         pick;
      int         len;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         addr = {($urandom_range(0, 3) != 0), cur_cfg.own_address};
      else if (pick < 75)
         addr = cur_cfg.broadcast_address;
      else
         addr = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 8)       len = 0;
      else if (pick < 75) len = $urandom_range(1, 6);
      else if (pick < 97) len = $urandom_range(7, 20);
      else                len = $urandom_range(200, 255);
      send_frame(addr, len, $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 12);
   endtask

   task automatic noise_burst();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      chained = 1'b0;
      force_reset = ($urandom_range(0, 3) != 0);
   endtask

   task automatic truncated_frame();
      int len;
      int part;
      len  = $urandom_range(2, 9);
      part = $urandom_range(0, len - 1);
      if (!chained) send_byte(cur_cfg.start_marker, 1'b0);
      send_byte({1'b1, cur_cfg.own_address}, 1'b0);
      send_byte(8'(len), 1'b0);
      repeat (part) send_byte(8'($urandom_range(0, 255)), 1'b0);
      chained = 1'b0;
      force_reset = 1'b1;
   endtask

   task automatic run_traffic(input int budget);
      int stop_at;
      int pick;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 78)      random_frame();
         else if (pick < 90) noise_burst();
         else                truncated_frame();
      end
   endtask

   initial begin
      cur_cfg = '{start_marker: START_MARKER_RESET, request_mask: REQUEST_MASK_RESET,
                  own_address: OWN_ADDRESS_RESET, broadcast_address: BROADCAST_RESET,
                  check_enable: CHECK_ENABLE_RESET};
      plans[0] = '{start_marker: 8'hFF, request_mask: 8'hFF, own_address: 7'h7F,
                   broadcast_address: 8'h00, check_enable: 1'b1};
      plans[1] = '{start_marker: 8'($urandom), request_mask: 8'($urandom),
                   own_address: 7'($urandom), broadcast_address: 8'($urandom),
                   check_enable: 1'b0};
      plans[2] = '{start_marker: 8'h00, request_mask: 8'h00, own_address: 7'($urandom),
                   broadcast_address: 8'hFF, check_enable: 1'b1};
      plans[3] = '{start_marker: 8'($urandom), request_mask: 8'($urandom | 8'h80),
                   own_address: 7'($urandom), broadcast_address: 8'($urandom),
                   check_enable: 1'b1};
      plans[4] = '{start_marker: 8'h7E, request_mask: 8'h80, own_address: 7'h00,
                   broadcast_address: 8'hFF, check_enable: 1'b0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: long payload with a bad sum, broadcast of zero length,
      // an abandoned frame, then a foreign frame whose checksum opens the next.
      send_frame(8'h80, 7, 1'b1, 1'b0);
      send_frame(8'hFF, 0, 1'b0, 1'b0);
      send_byte(cur_cfg.start_marker, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h03, 1'b0);
      force_reset = 1'b1;
      chained = 1'b0;
      send_frame(8'h05, 1, 1'b0, 1'b1);
      send_frame(8'h80, 1, 1'b0, 1'b0);

      run_traffic(200);

      for (int p = 0; p < 5; p++) begin
         settle();
         calm = (p == 3);
         apply_settings(plans[p]);
         chained = 1'b0;
         force_reset = 1'b1;
         run_traffic((p == 2) ? 100 : 270);
      end

      settle();
      if (sb.fault_count == 0 && sb.outstanding() == 0) begin
         $display("addressed_command_frame_receiver_core verification clean");
      end else begin
         $display("addressed_command_frame_receiver_core verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/acfr_pkg.sv
sv/acfr_parser.sv
sv/acfr_queue.sv
sv/acfr_emitter.sv
sv/addressed_command_frame_receiver_core.sv
sv/acfr_checker.sv
sim/addressed_command_frame_receiver_core_tb.sv
